[rtl/core/pal_pkg.sv]
// Shared types, codes and constants of the positional array list.
package pal_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W = 32;
  localparam int POS_W = 6;
  localparam int CMP_W = 8;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_DUMP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] CELL_HOLD = 3'd0;
  localparam logic [2:0] CELL_APPEND = 3'd1;
  localparam logic [2:0] CELL_INSERT = 3'd2;
  localparam logic [2:0] CELL_DELETE = 3'd3;
  localparam logic [2:0] CELL_ROTATE = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic [CMP_W-1:0]        pos;
    logic [CMP_W-1:0]        cnt;
    logic signed [DATA_W-1:0] value;
  } pal_cmd_t;

endpackage

[rtl/core/positional_array_list.sv]
// Top level of the positional array list: command decode, count and result register.
// Append, insert and delete give a registered result in the cycle after they are accepted.
// A dump of n entries stalls the command side from its acceptance until its last entry is out, and
// emits one entry per cycle while the result side is free, rotating the cell row once round.
// Throughput is one command per cycle except during a dump or a stalled result.
// Reset is synchronous and active high: it empties the list; cell contents are not cleared.
module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [1:0]               opcode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [DATA_W-1:0] value,
  output logic                     res_valid,
  input  logic                     res_stall,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] data,
  output logic [POS_W-1:0]         index,
  output logic [POS_W-1:0]         count,
  output logic                     last
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic [CW-1:0] dump_idx;
  logic          busy;
  logic          out_free;
  logic          accept;
  logic          dump_step;
  logic          dump_last;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic          full;
  logic [1:0]    st;
  logic signed [DATA_W-1:0] dat;
  logic [POS_W-1:0] idx;
  pal_cmd_t      cmd;
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W-1:0] sel;

  assign out_free = !res_valid || !res_stall;
  assign cmd_stall = busy || !out_free;
  assign accept = cmd_valid && !cmd_stall;
  assign dump_step = busy && out_free;
  assign dump_last = (CMP_W'(dump_idx) + CMP_W'(1)) == cnt_ext;
  assign pos_ext = CMP_W'(position);
  assign cnt_ext = CMP_W'(cnt);
  assign full = cnt_ext == FULL_CNT;

  always_comb begin
    st = ST_OK;
    dat = '0;
    idx = position;
    cnt_next = cnt;
    cmd.op = CELL_HOLD;
    cmd.pos = pos_ext;
    cmd.cnt = cnt_ext;
    cmd.value = value;
    if (dump_step) begin
      cmd.op = CELL_ROTATE;
    end else if (accept) begin
      unique case (opcode)
        OP_APPEND: begin
          if (full) begin
            st = ST_FULL;
            idx = '0;
          end else begin
            cmd.op = CELL_APPEND;
            idx = POS_W'(cnt);
            cnt_next = cnt + CW'(1);
          end
        end
        OP_INSERT: begin
          if (full) begin
            st = ST_FULL;
          end else if (pos_ext > cnt_ext) begin
            st = ST_RANGE;
          end else begin
            cmd.op = CELL_INSERT;
            cnt_next = cnt + CW'(1);
          end
        end
        OP_DELETE: begin
          if (cnt == '0) begin
            st = ST_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            st = ST_RANGE;
          end else begin
            cmd.op = CELL_DELETE;
            dat = sel;
            cnt_next = cnt - CW'(1);
          end
        end
        OP_DUMP: begin
          st = ST_EMPTY;
          idx = '0;
        end
        default: st = ST_OK;
      endcase
    end
  end

  pal_chain #(.DEPTH(DEPTH)) u_chain (
    .clk  (clk),
    .cmd  (cmd),
    .head (head),
    .sel  (sel)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      busy <= 1'b0;
      cnt <= '0;
      dump_idx <= '0;
    end else begin
      cnt <= cnt_next;
      if (dump_step) begin
        res_valid <= 1'b1;
        dump_idx <= dump_idx + CW'(1);
        if (dump_last) busy <= 1'b0;
      end else if (accept) begin
        if (opcode == OP_DUMP && cnt != '0) begin
          res_valid <= 1'b0;
          busy <= 1'b1;
          dump_idx <= '0;
        end else begin
          res_valid <= 1'b1;
        end
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dump_step) begin
      status <= ST_OK;
      data <= head;
      index <= POS_W'(dump_idx);
      count <= POS_W'(cnt);
      last <= dump_last;
    end else if (accept) begin
      status <= st;
      data <= dat;
      index <= idx;
      count <= POS_W'(cnt_next);
      last <= 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(cnt) <= FULL_CNT)
    else $error("entry count exceeds the list depth");

  a_dump_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && opcode == OP_DUMP && cnt != '0) |=> busy)
    else $error("dump of a non-empty list did not start");

  a_count_held: assert property (@(posedge clk) disable iff (rst)
    busy |=> cnt == $past(cnt))
    else $error("entry count changed during a dump");

  a_partial_in_dump: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !last) |-> busy)
    else $error("non-final result outside a dump");

endmodule

[rtl/core/pal_cell.sv]
// One storage cell of the list, loading from its neighbours, from the head cell or from the command.
module pal_cell
  import pal_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  pal_cmd_t                 cmd,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  input  logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0] val
);

  localparam logic [CMP_W-1:0] ME = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] ME_PLUS = CMP_W'(IDX + 1);

  logic signed [DATA_W-1:0] val_next;

  always_comb begin
    val_next = val;
    unique case (cmd.op)
      CELL_APPEND: begin
        if (ME == cmd.cnt) val_next = cmd.value;
      end
      CELL_INSERT: begin
        if (ME == cmd.pos) val_next = cmd.value;
        else if (ME > cmd.pos && ME <= cmd.cnt) val_next = left;
      end
      CELL_DELETE: begin
        if (ME >= cmd.pos && ME_PLUS < cmd.cnt) val_next = right;
      end
      CELL_ROTATE: begin
        if (ME_PLUS < cmd.cnt) val_next = right;
        else if (ME_PLUS == cmd.cnt) val_next = head;
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

[rtl/core/pal_chain.sv]
// Row of list cells with the head tap and the positional read-out.
module pal_chain
  import pal_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  pal_cmd_t                 cmd,
  output logic signed [DATA_W-1:0] head,
  output logic signed [DATA_W-1:0] sel
);

  logic signed [DATA_W-1:0] vals [DEPTH];

  assign head = vals[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;
    if (i == 0) begin : g_first
      assign left_in = cmd.value;
    end else begin : g_mid
      assign left_in = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in = vals[i];
    end else begin : g_inner
      assign right_in = vals[i+1];
    end
    pal_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .left  (left_in),
      .right (right_in),
      .head  (vals[0]),
      .val   (vals[i])
    );
  end

  always_comb begin
    sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CMP_W'(i) == cmd.pos) sel = vals[i];
    end
  end

endmodule

[tb/testbench.sv]
// Self-checking testbench for the positional array list: directed and random commands.
`timescale 1ns / 100ps

import pal_pkg::*;

localparam int LIST_DEPTH = DEPTH_DEFAULT;

typedef struct {
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [POS_W-1:0]         index;
  logic [POS_W-1:0]         count;
  logic                     last;
} list_result_t;

class list_scoreboard;
  logic signed [DATA_W-1:0] cells [LIST_DEPTH];
  int fill;
  list_result_t pending_results [$];
  int failures;
  int commands;
  int dumps;
  int results_checked;
  int status_seen [4];

  function new();
    fill = 0;
    failures = 0;
    commands = 0;
    dumps = 0;
    results_checked = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (cells[i]) cells[i] = '0;
  endfunction

  function void note_command(logic [1:0] op, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
    list_result_t r;
    int i;
    r.status = ST_OK;
    r.data = '0;
    r.index = '0;
    r.count = '0;
    r.last = 1'b1;
    commands++;
    case (op)
      OP_APPEND: begin
        if (fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          cells[fill] = val;
          fill++;
          r.index = POS_W'(fill - 1);
        end
      end
      OP_INSERT: begin
        r.index = pos;
        if (fill >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else if (int'(pos) > fill) begin
          r.status = ST_RANGE;
        end else begin
          for (i = fill; i > int'(pos); i--) cells[i] = cells[i-1];
          cells[pos] = val;
          fill++;
        end
      end
      OP_DELETE: begin
        r.index = pos;
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= fill) begin
          r.status = ST_RANGE;
        end else begin
          r.data = cells[pos];
          for (i = int'(pos); i + 1 < fill; i++) cells[i] = cells[i+1];
          fill--;
        end
      end
      default: begin
        dumps++;
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (i = 0; i < fill; i++) begin
            r.data = cells[i];
            r.index = POS_W'(i);
            r.count = POS_W'(fill);
            r.last = (i + 1 == fill);
            pending_results.push_back(r);
          end
          return;
        end
      end
    endcase
    r.count = POS_W'(fill);
    pending_results.push_back(r);
  endfunction

  function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] dt,
                             logic [POS_W-1:0] ix, logic [POS_W-1:0] ct, logic lt);
    list_result_t e;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d data %0d index %0d count %0d last %0d",
             st, dt, ix, ct, lt);
      failures++;
      return;
    end
    e = pending_results.pop_front();
    results_checked++;
    status_seen[e.status]++;
    if (st !== e.status) begin
      $error("status mismatch: expected %0d, got %0d", e.status, st);
      failures++;
    end
    if (dt !== e.data) begin
      $error("data mismatch: expected %0d, got %0d", e.data, dt);
      failures++;
    end
    if (ix !== e.index) begin
      $error("index mismatch: expected %0d, got %0d", e.index, ix);
      failures++;
    end
    if (ct !== e.count) begin
      $error("count mismatch: expected %0d, got %0d", e.count, ct);
      failures++;
    end
    if (lt !== e.last) begin
      $error("last mismatch: expected %0d, got %0d", e.last, lt);
      failures++;
    end
  endfunction
endclass

module testbench;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 470;
  localparam int SEGMENT_LEN = 60;

  logic                     clk;
  logic                     rst;
  logic                     cmd_valid;
  logic                     cmd_stall;
  logic [1:0]               opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;
  logic                     res_valid;
  logic                     res_stall;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] data;
  logic [POS_W-1:0]         index;
  logic [POS_W-1:0]         count;
  logic                     last;

  logic calm;
  int idle_cycles;
  list_scoreboard sb;

  positional_array_list #(
    .DEPTH(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .opcode(opcode),
    .position(position),
    .value(value),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .data(data),
    .index(index),
    .count(count),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    res_stall <= !calm && ($urandom_range(0, 99) < 9);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) sb.note_command(opcode, position, value);
      if (res_valid && !res_stall) sb.check_result(status, data, index, count, last);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[positional_array_list] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_command(input logic [1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] val);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    opcode <= op;
    position <= pos;
    value <= val;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  task automatic send_random(input bit growing);
    int r;
    logic [1:0] op;
    logic [POS_W-1:0] pos;
    #1;
    r = $urandom_range(0, 99);
    if (r < 8) op = OP_DUMP;
    else if (growing) op = (r < 55) ? OP_APPEND : (r < 85) ? OP_INSERT : OP_DELETE;
    else op = (r < 25) ? OP_APPEND : (r < 45) ? OP_INSERT : OP_DELETE;
    pos = POS_W'($urandom_range(0, LIST_DEPTH));
    if (op == OP_INSERT && $urandom_range(0, 99) < 85) begin
      pos = POS_W'($urandom_range(0, sb.fill));
    end else if (op == OP_DELETE && sb.fill > 0 && $urandom_range(0, 99) < 85) begin
      pos = POS_W'($urandom_range(0, sb.fill - 1));
    end
    send_command(op, pos, pick_value());
  endtask

  initial begin
    int i;
    sb = new();
    calm = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    cmd_valid = 1'b0;
    opcode = OP_APPEND;
    position = '0;
    value = '0;
    res_stall = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_command(OP_DUMP, 6'd0, 32'sd0);
    send_command(OP_DELETE, 6'd0, 32'sd0);
    send_command(OP_DELETE, 6'd32, 32'sd0);
    send_command(OP_INSERT, 6'd1, 32'sd7);
    send_command(OP_APPEND, 6'd63, 32'sh7fffffff);
    send_command(OP_APPEND, 6'd0, 32'sh80000000);
    send_command(OP_APPEND, 6'd0, 32'sd0);
    send_command(OP_APPEND, 6'd0, -32'sd1);
    send_command(OP_INSERT, 6'd0, 32'sh55555555);
    send_command(OP_INSERT, 6'd5, 32'shaaaaaaaa);
    send_command(OP_INSERT, 6'd7, 32'sd1);
    send_command(OP_INSERT, 6'd32, 32'sd2);
    send_command(OP_DUMP, 6'd0, 32'sd0);
    send_command(OP_DELETE, 6'd6, 32'sd0);
    send_command(OP_DELETE, 6'd32, 32'sd0);
    send_command(OP_DELETE, 6'd0, 32'sd0);
    send_command(OP_DELETE, 6'd4, 32'sd0);
    send_command(OP_DELETE, 6'd2, 32'sd0);
    send_command(OP_DUMP, 6'd0, 32'sd0);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      calm = ((i / SEGMENT_LEN) == 3);
      send_random(((i / SEGMENT_LEN) % 2) == 0);
    end
    calm = 1'b0;
    @(negedge clk);
    cmd_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Covered %0d commands including %0d dumps; %0d results checked.",
             sb.commands, sb.dumps, sb.results_checked);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, out of range %0d.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_RANGE]);
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("[positional_array_list] OK");
    end else begin
      $display("[positional_array_list] ERROR");
    end
    $finish;
  end

endmodule
